@@ design/rle_glyph_row_run_expander_defines.svh @@
// Assertion macros for the run-length glyph row expander.
// Included by the top level; needs no other file.
`ifndef RLE_GLYPH_ROW_RUN_EXPANDER_DEFINES_SVH
`define RLE_GLYPH_ROW_RUN_EXPANDER_DEFINES_SVH

`ifndef SYNTHESIS
`define RGRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rgre assertion failed");
`define RGRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rgre assertion failed");
`else
`define RGRE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RGRE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/rgre_pkg.sv @@
// Shared types, constants and helpers of the run-length glyph row expander.
// No dependencies.
`default_nettype none

package rgre_pkg;

	localparam logic [7:0] FG_FLAG  = 8'h80;
	localparam logic [7:0] LEN_MASK = 8'h7F;
	localparam logic [7:0] MIN_WIDTH = 8'd3;

	localparam logic [2:0] REG_WIDTH    = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_SCALE    = 3'd2;
	localparam logic [2:0] REG_ORIGIN_X = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
	localparam logic [2:0] REG_FG       = 3'd5;
	localparam logic [2:0] REG_BG       = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	typedef struct packed {
		logic [7:0]         glyph_width;
		logic [7:0]         glyph_height;
		logic [3:0]         scale;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        fg_color;
		logic [15:0]        bg_color;
	} cfg_t;

	typedef struct packed {
		logic [7:0] len;
		logic [7:0] col;
		logic [8:0] row;
		logic [7:0] width;
	} seg_in_t;

	typedef struct packed {
		logic [7:0]         rem_len;
		logic [7:0]         next_col;
		logic [8:0]         next_row;
		logic signed [15:0] run_x;
		logic signed [15:0] run_y;
		logic [10:0]        run_length;
		logic               last;
	} seg_out_t;

	function automatic logic [7:0] eff_width(input logic [7:0] w);
		logic [7:0] r;
		r = w;
		if (w != 8'd0 && w < MIN_WIDTH) begin
			r = MIN_WIDTH;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/rgre_apb_regs.sv @@
// APB register file holding the glyph geometry, scale, origin and colors.
// Depends on rgre_pkg.
`default_nettype none

module rgre_apb_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output rgre_pkg::cfg_t     cfg
);

	logic [2:0] idx;
	logic       wr_en;
	rgre_pkg::cfg_t cfg_q;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width  <= 8'd8;
			cfg_q.glyph_height <= 8'd8;
			cfg_q.scale        <= 4'd1;
			cfg_q.origin_x     <= 16'sd0;
			cfg_q.origin_y     <= 16'sd0;
			cfg_q.fg_color     <= 16'hFFFF;
			cfg_q.bg_color     <= 16'h0000;
		end else if (wr_en) begin
			case (idx)
				rgre_pkg::REG_WIDTH:    cfg_q.glyph_width  <= pwdata[7:0];
				rgre_pkg::REG_HEIGHT:   cfg_q.glyph_height <= pwdata[7:0];
				rgre_pkg::REG_SCALE:    cfg_q.scale        <= pwdata[3:0];
				rgre_pkg::REG_ORIGIN_X: cfg_q.origin_x     <= pwdata[15:0];
				rgre_pkg::REG_ORIGIN_Y: cfg_q.origin_y     <= pwdata[15:0];
				rgre_pkg::REG_FG:       cfg_q.fg_color     <= pwdata[15:0];
				rgre_pkg::REG_BG:       cfg_q.bg_color     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rgre_pkg::REG_WIDTH:    prdata = {24'd0, cfg_q.glyph_width};
			rgre_pkg::REG_HEIGHT:   prdata = {24'd0, cfg_q.glyph_height};
			rgre_pkg::REG_SCALE:    prdata = {28'd0, cfg_q.scale};
			rgre_pkg::REG_ORIGIN_X: prdata = {16'd0, cfg_q.origin_x};
			rgre_pkg::REG_ORIGIN_Y: prdata = {16'd0, cfg_q.origin_y};
			rgre_pkg::REG_FG:       prdata = {16'd0, cfg_q.fg_color};
			rgre_pkg::REG_BG:       prdata = {16'd0, cfg_q.bg_color};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ design/rgre_seg_unit.sv @@
// Shared segment unit: cuts one row segment off the pending run and computes
// its scaled screen rectangle. Depends on rgre_pkg.
`default_nettype none

module rgre_seg_unit (
	input  wire rgre_pkg::seg_in_t  si,
	input  wire logic [3:0]         scale,
	input  wire logic signed [15:0] origin_x,
	input  wire logic signed [15:0] origin_y,
	output rgre_pkg::seg_out_t      so
);

	logic [7:0]  room;
	logic [7:0]  seg;
	logic [7:0]  col_sum;
	logic [11:0] x_prod;
	logic [12:0] y_prod;
	logic [11:0] l_prod;

	always_comb begin
		room    = si.width - si.col;
		seg     = (si.len < room) ? si.len : room;
		col_sum = si.col + seg;
		x_prod  = {4'd0, si.col} * {8'd0, scale};
		y_prod  = {4'd0, si.row} * {9'd0, scale};
		l_prod  = {4'd0, seg} * {8'd0, scale};

		so.rem_len    = si.len - seg;
		so.last       = (si.len == seg);
		so.run_x      = origin_x + signed'({4'd0, x_prod});
		so.run_y      = origin_y + signed'({3'd0, y_prod});
		so.run_length = l_prod[10:0];
		if (col_sum >= si.width) begin
			so.next_col = 8'd0;
			so.next_row = si.row + 9'd1;
		end else begin
			so.next_col = col_sum;
			so.next_row = si.row;
		end
	end

endmodule

`default_nettype wire

@@ design/rle_glyph_row_run_expander.sv @@
// Top level of the run-length glyph row expander: sequencer, position state
// and output register. Depends on rgre_pkg, rgre_apb_regs, rgre_seg_unit and the defines header.
//
// Each accepted code byte is one run of a glyph; the block turns it into
// filled rectangles, one per glyph row that the run touches, scaled and
// placed at the configured origin. A byte is taken only while the block is
// idle; it then goes through accept and setup, and a single segment unit
// cuts one segment a cycle while no output beat is held; a hidden
// background run still walks its segments without emitting. A held output
// beat stalls the segment walk. Bytes that arrive after the glyph's pixel
// total pass through accept and setup and produce nothing.
`default_nettype none
`include "rle_glyph_row_run_expander_defines.svh"

module rle_glyph_row_run_expander (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // code_byte
	input  wire logic        s_tuser,  // glyph_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // run_x, run_y, run_length, run_color, zero pad
	output logic             m_tlast   // last_run
);

	rgre_pkg::cfg_t     cfg;
	rgre_pkg::state_t   state_q;
	rgre_pkg::seg_in_t  si;
	rgre_pkg::seg_out_t so;

	logic [7:0]  code_q;
	logic        start_q;
	logic [16:0] pc_q;
	logic [7:0]  col_q;
	logic [8:0]  row_q;
	logic [7:0]  len_q;
	logic        plot_q;
	logic [15:0] color_q;

	logic               out_valid_q;
	logic               out_last_q;
	logic signed [15:0] out_x_q;
	logic signed [15:0] out_y_q;
	logic [10:0]        out_len_q;
	logic [15:0]        out_color_q;

	logic [7:0]  w;
	logic [15:0] total;
	logic [16:0] pc0;
	logic [7:0]  col0;
	logic [8:0]  row0;
	logic        fg;
	logic        run_go;

	rgre_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign w     = rgre_pkg::eff_width(cfg.glyph_width);
	assign total = {8'd0, w} * {8'd0, cfg.glyph_height};
	assign pc0   = start_q ? 17'd0 : pc_q;
	assign col0  = start_q ? 8'd0 : col_q;
	assign row0  = start_q ? 9'd0 : row_q;
	assign fg    = (code_q & rgre_pkg::FG_FLAG) != 8'd0;

	assign si.len   = len_q;
	assign si.col   = col_q;
	assign si.row   = row_q;
	assign si.width = w;

	rgre_seg_unit u_seg (
		.si       (si),
		.scale    (cfg.scale),
		.origin_x (cfg.origin_x),
		.origin_y (cfg.origin_y),
		.so       (so)
	);

	assign s_tready = (state_q == rgre_pkg::ST_IDLE);
	assign run_go   = (state_q == rgre_pkg::ST_RUN) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgre_pkg::ST_IDLE;
			pc_q    <= 17'd0;
			col_q   <= 8'd0;
			row_q   <= 9'd0;
		end else begin
			case (state_q)
				rgre_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= rgre_pkg::ST_PREP;
					end
				end
				rgre_pkg::ST_PREP: begin
					if (pc0 >= {1'b0, total}) begin
						pc_q    <= pc0;
						col_q   <= col0;
						row_q   <= row0;
						state_q <= rgre_pkg::ST_IDLE;
					end else begin
						pc_q <= pc0 + {9'd0, (code_q & rgre_pkg::LEN_MASK)} + 17'd1;
						if (col0 >= w) begin
							col_q <= 8'd0;
							row_q <= row0 + 9'd1;
						end else begin
							col_q <= col0;
							row_q <= row0;
						end
						state_q <= rgre_pkg::ST_RUN;
					end
				end
				rgre_pkg::ST_RUN: begin
					if (run_go) begin
						col_q <= so.next_col;
						row_q <= so.next_row;
						if (so.last) begin
							state_q <= rgre_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= rgre_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_q  <= s_tdata;
			start_q <= s_tuser;
		end
		if (state_q == rgre_pkg::ST_PREP) begin
			len_q   <= (code_q & rgre_pkg::LEN_MASK) + 8'd1;
			plot_q  <= fg || (cfg.fg_color != cfg.bg_color);
			color_q <= fg ? cfg.fg_color : cfg.bg_color;
		end else if (run_go) begin
			len_q <= so.rem_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run_go) begin
			out_valid_q <= plot_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_go && plot_q) begin
			out_x_q     <= so.run_x;
			out_y_q     <= so.run_y;
			out_len_q   <= so.run_length;
			out_color_q <= color_q;
			out_last_q  <= so.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_color_q, out_len_q, out_y_q, out_x_q};

	`RGRE_ASSERT_IMP(a_run_col_in_row, clk, arst_n, (state_q == rgre_pkg::ST_RUN), (col_q < w))
	`RGRE_ASSERT_IMP(a_run_len_nonzero, clk, arst_n, (state_q == rgre_pkg::ST_RUN), (len_q != 8'd0))
	`RGRE_ASSERT_NXT(a_prep_one_cycle, clk, arst_n, (state_q == rgre_pkg::ST_PREP), (state_q == rgre_pkg::ST_IDLE || state_q == rgre_pkg::ST_RUN))

endmodule

`default_nettype wire

@@ tb/sv/rle_glyph_row_run_expander_test.sv @@
// Self-checking testbench for rle_glyph_row_run_expander: APB setup, code byte stream in,
// rectangle run stream out, checked against an in-bench model of the run expansion.
// Depends on rgre_pkg and the design sources only.
module rle_glyph_row_run_expander_test;
	import rgre_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [10:0] len;
		logic [15:0] color;
		logic        last;
	} rect_t;

	class run_scoreboard;
		logic [7:0]  width;
		logic [7:0]  height;
		logic [3:0]  scale;
		logic [15:0] org_x;
		logic [15:0] org_y;
		logic [15:0] fg;
		logic [15:0] bg;
		logic [16:0] pix_done;
		logic [7:0]  col;
		logic [8:0]  row;
		rect_t       pending[$];
		int          errors;

		function new();
			width = 8'd8;
			height = 8'd8;
			scale = 4'd1;
			org_x = 16'h0000;
			org_y = 16'h0000;
			fg = 16'hFFFF;
			bg = 16'h0000;
			pix_done = '0;
			col = '0;
			row = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_WIDTH: width = v[7:0];
				REG_HEIGHT: height = v[7:0];
				REG_SCALE: scale = v[3:0];
				REG_ORIGIN_X: org_x = v[15:0];
				REG_ORIGIN_Y: org_y = v[15:0];
				REG_FG: fg = v[15:0];
				REG_BG: bg = v[15:0];
				default: ;
			endcase
		endfunction

		// Returns 1 when the byte is used, 0 when the glyph is already complete.
		function bit note_byte(logic [7:0] code, bit start);
			logic [7:0]  w;
			logic [7:0]  left;
			logic [7:0]  room;
			logic [7:0]  seg;
			logic [16:0] total;
			logic [15:0] color;
			bit          visible;
			bit          have;
			rect_t       r;
			if (start) begin
				pix_done = '0;
				col = '0;
				row = '0;
			end
			w = (width != 8'd0 && width < MIN_WIDTH) ? MIN_WIDTH : width;
			total = 17'(w) * 17'(height);
			if (pix_done >= total) begin
				return 1'b0;
			end
			left = (code & LEN_MASK) + 8'd1;
			color = ((code & FG_FLAG) != 8'd0) ? fg : bg;
			visible = ((code & FG_FLAG) != 8'd0) || (fg != bg);
			if (col >= w) begin
				col = '0;
				row = row + 9'd1;
			end
			pix_done = pix_done + left;
			have = 1'b0;
			r = '0;
			while (left != 8'd0) begin
				room = w - col;
				seg = (left < room) ? left : room;
				if (visible) begin
					if (have) begin
						pending.push_back(r);
					end
					r.x = org_x + scale * col;
					r.y = org_y + scale * row;
					r.len = 11'(seg) * 11'(scale);
					r.color = color;
					r.last = 1'b0;
					have = 1'b1;
				end
				left = left - seg;
				col = col + seg;
				if (col >= w) begin
					col = '0;
					row = row + 9'd1;
				end
			end
			if (have) begin
				r.last = 1'b1;
				pending.push_back(r);
			end
			return 1'b1;
		endfunction

		function void check_rect(logic [63:0] data, logic last);
			rect_t got;
			rect_t want;
			got.x = data[15:0];
			got.y = data[31:16];
			got.len = data[42:32];
			got.color = data[58:43];
			got.last = last;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Unexpected run beat: x %h y %h len %0d color %h last %b",
						got.x, got.y, got.len, got.color, got.last);
				end
				return;
			end
			want = pending.pop_front();
			if (got.x != want.x || got.y != want.y || got.len != want.len ||
					got.color != want.color || got.last != want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("Run mismatch: expected x %h y %h len %0d color %h last %b",
						want.x, want.y, want.len, want.color, want.last);
					$display("              actual   x %h y %h len %0d color %h last %b",
						got.x, got.y, got.len, got.color, got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // code_byte
	logic        s_tuser;  // glyph_start
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;  // run_x, run_y, run_length, run_color, zero pad
	logic        m_tlast;  // last_run

	run_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int taken_count;
	int quiet_cycles;
	int hold_left;
	bit hold_go;
	bit hold_seen;

	rle_glyph_row_run_expander dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_rect(m_tdata, m_tlast);
		end
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic set_pace(int mode);
		case (mode)
			1: begin
				send_idle_pct = 58;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 58;
			end
			3: begin
				send_idle_pct = 27;
				recv_stall_pct = 27;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [7:0] w, logic [7:0] h, logic [3:0] s,
			logic [15:0] ox, logic [15:0] oy, logic [15:0] fgc, logic [15:0] bgc);
		write_reg(REG_WIDTH, {24'd0, w});
		write_reg(REG_HEIGHT, {24'd0, h});
		write_reg(REG_SCALE, {28'd0, s});
		write_reg(REG_ORIGIN_X, {16'd0, ox});
		write_reg(REG_ORIGIN_Y, {16'd0, oy});
		write_reg(REG_FG, {16'd0, fgc});
		write_reg(REG_BG, {16'd0, bgc});
	endtask

	task automatic send_byte(logic [7:0] code, bit start);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		if (sb.note_byte(code, start)) begin
			taken_count++;
		end
	endtask

	// Ignored bytes and hidden background runs keep the block busy with no
	// output, so a fixed settle time follows the last expected beat.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  code;
		logic [7:0]  w;
		logic [7:0]  h;
		logic [15:0] fgc;
		bit          start;
		bit          new_glyph;
		int          prev;
		int          ph;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		taken_count = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_go = 1'b0;
		hold_seen = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		m_tready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a run that overflows the glyph, then bytes past its end.
		set_pace(0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h05, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h00, 1'b0);
		drain();

		// Narrowest glyph, largest scale, hidden background, longest splits.
		set_pace(3);
		set_config(8'd3, 8'd1, 4'd15, 16'h7FFF, 16'h8000, 16'h1234, 16'h1234);
		send_byte(8'h02, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h81, 1'b1);
		send_byte(8'hFF, 1'b0);
		drain();

		// Widest glyph with zero scale.
		set_pace(1);
		set_config(8'd255, 8'd255, 4'd0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h83, 1'b0);
		drain();

		// Width lowered mid-glyph below the current column.
		set_pace(2);
		set_config(8'd2, 8'd255, 4'd1, 16'h0010, 16'hFFF0, 16'hF800, 16'h07E0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		drain();

		set_config(8'd0, 8'd8, 4'd3, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		send_byte(8'h80, 1'b1);
		drain();

		set_config(8'd1, 8'd2, 4'd2, 16'hFFFE, 16'h0001, 16'hABCD, 16'h5432);
		send_byte(8'h85, 1'b1);
		send_byte(8'h00, 1'b0);
		drain();

		taken_count = 0;
		ph = 0;
		while (ph < 7) begin
			ph++;
			case ($urandom_range(7))
				0: w = 8'($urandom_range(255));
				1: w = ($urandom_range(1) != 0) ? 8'd255 : 8'($urandom_range(2));
				default: w = 8'($urandom_range(3, 12));
			endcase
			h = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 6));
			fgc = 16'($urandom_range(16'hFFFF));
			set_config(w, h, 4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)),
				16'($urandom_range(16'hFFFF)), fgc,
				($urandom_range(3) == 0) ? fgc : 16'($urandom_range(16'hFFFF)));
			set_pace(ph % 4);
			if (ph == 4) begin
				hold_go <= !hold_go;
			end
			new_glyph = 1'b1;
			repeat (20) begin
				start = ($urandom_range(15) == 0) ? bit'($urandom_range(1)) : new_glyph;
				code[7] = 1'($urandom_range(1));
				code[6:0] = 7'(($urandom_range(3) != 0) ? $urandom_range(15) :
					$urandom_range(127));
				prev = taken_count;
				send_byte(code, start);
				new_glyph = (taken_count == prev) || ($urandom_range(7) == 0);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
